// File: design/wlcm_pkg.sv
// Shared types and constants for the wear-leveling cached memory.
package wlcm_pkg;

   localparam int MAIN_WORDS  = 1024;
   localparam int CACHE_WORDS = 64;
   localparam int WORD_BITS   = 16;
   localparam int ADDR_BITS   = $clog2(MAIN_WORDS);
   localparam int SLOT_BITS   = $clog2(CACHE_WORDS);
   localparam int FILL_BITS   = SLOT_BITS + 1;

   typedef enum logic [2:0] {
      OP_READ   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_FLUSH  = 3'd2,
      OP_REMAP  = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   typedef enum logic [8:0] {
      S_CLEAR = 9'b000000001,
      S_IDLE  = 9'b000000010,
      S_MAP   = 9'b000000100,
      S_TAG   = 9'b000001000,
      S_DEC   = 9'b000010000,
      S_FRD   = 9'b000100000,
      S_FWR   = 9'b001000000,
      S_FILL  = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   typedef struct packed {
      logic                 map_we;
      logic                 line_we;
      logic                 dirty;
      logic [SLOT_BITS-1:0] slot;
      logic [ADDR_BITS-1:0] addr;
      logic [WORD_BITS-1:0] data;
      logic [ADDR_BITS-1:0] rd_addr;
      logic [SLOT_BITS-1:0] rd_slot;
   } cache_cmd_type;

   typedef struct packed {
      logic [SLOT_BITS-1:0] map_slot;
      logic [ADDR_BITS-1:0] tag;
      logic [WORD_BITS-1:0] data;
      logic                 dirty;
   } cache_rsp_type;

endpackage

// File: design/wlcm_main.sv
// Main word store: one write port, one registered read port.
module wlcm_main (
   input  logic                           clock,
   input  logic                           we,
   input  logic [wlcm_pkg::ADDR_BITS-1:0] waddr,
   input  logic [wlcm_pkg::WORD_BITS-1:0] wdata,
   input  logic [wlcm_pkg::ADDR_BITS-1:0] raddr,
   output logic [wlcm_pkg::WORD_BITS-1:0] rdata
);

   logic [wlcm_pkg::WORD_BITS-1:0] mem [wlcm_pkg::MAIN_WORDS];
   logic [wlcm_pkg::WORD_BITS-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: design/wlcm_cache.sv
// Write cache: slot map, line tags, line data and dirty flags.
module wlcm_cache (
   input  logic                    clock,
   input  logic                    reset,
   input  wlcm_pkg::cache_cmd_type cmd,
   output wlcm_pkg::cache_rsp_type rsp
);

   logic [wlcm_pkg::SLOT_BITS-1:0] map_mem  [wlcm_pkg::MAIN_WORDS];
   logic [wlcm_pkg::ADDR_BITS-1:0] tag_mem  [wlcm_pkg::CACHE_WORDS];
   logic [wlcm_pkg::WORD_BITS-1:0] data_mem [wlcm_pkg::CACHE_WORDS];
   logic [wlcm_pkg::CACHE_WORDS-1:0] dirty_ff;
   wlcm_pkg::cache_rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd.map_we) begin
         map_mem[cmd.addr] <= cmd.slot;
      end
      if (cmd.line_we) begin
         tag_mem[cmd.slot]  <= cmd.addr;
         data_mem[cmd.slot] <= cmd.data;
      end
      rsp_ff.map_slot <= map_mem[cmd.rd_addr];
      rsp_ff.tag      <= tag_mem[cmd.rd_slot];
      rsp_ff.data     <= data_mem[cmd.rd_slot];
      rsp_ff.dirty    <= dirty_ff[cmd.rd_slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dirty_ff <= '0;
      end else if (cmd.line_we) begin
         dirty_ff[cmd.slot] <= cmd.dirty;
      end
   end

   assign rsp = rsp_ff;

endmodule

// File: design/wear_leveling_cached_memory.sv
// Top level: request sequencer of the wear-leveling cached memory.
//
// Requests arrive on req_* and one response per request leaves on rsp_*.
// One request is handled at a time; req_tready is high only when idle.
// Rotation is kept virtual: the store is indexed by the virtual address, so a
// remap costs only the flush that precedes it.
// A miss with a full cache first walks every slot and writes dirty lines back;
// flush and remap walk the filled slots the same way; clear sweeps the main
// store to zero, one word a cycle. Other opcodes return an all-zero response.
// The write-back walk and the zeroing sweep share the single main-store
// write port and one counter.
// After reset the block sweeps every word of the main store to zero
// before req_tready rises.
// The response is held in an output register; a stalled receiver holds the
// sequencer in its final state until the register is free.
module wear_leveling_cached_memory (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // opcode, address, write_data, shift_amount
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // read_data, cache_hit, flushed
);

   localparam int AB = wlcm_pkg::ADDR_BITS;
   localparam int WB = wlcm_pkg::WORD_BITS;
   localparam int SB = wlcm_pkg::SLOT_BITS;
   localparam int FB = wlcm_pkg::FILL_BITS;

   wlcm_pkg::state_type state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [AB-1:0] addr_ff, addr_in;
   logic [WB-1:0] data_ff, data_in;
   logic [AB-1:0] cnt_ff, cnt_in;
   logic [FB-1:0] fill_ff, fill_in;
   logic [SB-1:0] slot_ff, slot_in;
   logic [WB-1:0] mainq_ff, mainq_in;
   logic [WB-1:0] rd_ff, rd_in;
   logic          hit_ff, hit_in;
   logic          flushed_ff, flushed_in;
   logic          clr_rsp_ff, clr_rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [WB+1:0] rsp_ff, rsp_in;

   logic          main_we;
   logic [AB-1:0] main_waddr;
   logic [WB-1:0] main_wdata;
   logic [WB-1:0] main_rdata;
   wlcm_pkg::cache_cmd_type cmd;
   wlcm_pkg::cache_rsp_type crsp;

   logic req_acc, rsp_free, is_rw, is_write, hit;

   assign req_tready = (state_ff == wlcm_pkg::S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign is_write   = (op_ff == wlcm_pkg::OP_WRITE);
   assign is_rw      = (op_ff == wlcm_pkg::OP_READ) || is_write;
   assign hit        = ({1'b0, slot_ff} < fill_ff) && (crsp.tag == addr_ff);

   wlcm_main u_main (
      .clock (clock),
      .we    (main_we),
      .waddr (main_waddr),
      .wdata (main_wdata),
      .raddr (addr_ff),
      .rdata (main_rdata)
   );

   wlcm_cache u_cache (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rsp   (crsp)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      cnt_in       = cnt_ff;
      fill_in      = fill_ff;
      slot_in      = slot_ff;
      mainq_in     = mainq_ff;
      rd_in        = rd_ff;
      hit_in       = hit_ff;
      flushed_in   = flushed_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      main_we      = 1'b0;
      main_waddr   = cnt_ff;
      main_wdata   = '0;
      cmd          = '0;
      cmd.rd_addr  = addr_ff;
      cmd.rd_slot  = slot_ff;
      cmd.addr     = addr_ff;
      cmd.slot     = slot_ff;
      cmd.data     = data_ff;
      case (state_ff)
         wlcm_pkg::S_CLEAR: begin
            main_we = 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == AB'(wlcm_pkg::MAIN_WORDS - 1)) begin
               fill_in  = '0;
               state_in = clr_rsp_ff ? wlcm_pkg::S_DONE : wlcm_pkg::S_IDLE;
            end
         end
         wlcm_pkg::S_IDLE: begin
            if (req_acc) begin
               op_in      = req_tdata[2:0];
               addr_in    = req_tdata[12:3];
               data_in    = req_tdata[28:13];
               rd_in      = '0;
               hit_in     = 1'b0;
               flushed_in = 1'b0;
               cnt_in     = '0;
               case (req_tdata[2:0])
                  wlcm_pkg::OP_READ, wlcm_pkg::OP_WRITE: begin
                     state_in = wlcm_pkg::S_MAP;
                  end
                  wlcm_pkg::OP_FLUSH, wlcm_pkg::OP_REMAP: begin
                     flushed_in = 1'b1;
                     state_in   = (fill_ff == '0) ? wlcm_pkg::S_DONE : wlcm_pkg::S_FRD;
                  end
                  wlcm_pkg::OP_CLEAR: begin
                     clr_rsp_in = 1'b1;
                     state_in   = wlcm_pkg::S_CLEAR;
                  end
                  default: begin
                     state_in = wlcm_pkg::S_DONE;
                  end
               endcase
            end
         end
         wlcm_pkg::S_MAP: begin
            state_in = wlcm_pkg::S_TAG;
         end
         wlcm_pkg::S_TAG: begin
            cmd.rd_slot = crsp.map_slot;
            slot_in     = crsp.map_slot;
            mainq_in    = main_rdata;
            state_in    = wlcm_pkg::S_DEC;
         end
         wlcm_pkg::S_DEC: begin
            if (hit) begin
               hit_in   = 1'b1;
               state_in = wlcm_pkg::S_DONE;
               if (is_write) begin
                  cmd.line_we = 1'b1;
                  cmd.dirty   = 1'b1;
                  rd_in       = data_ff;
               end else begin
                  rd_in = crsp.data;
               end
            end else if (fill_ff == FB'(wlcm_pkg::CACHE_WORDS)) begin
               flushed_in = 1'b1;
               cnt_in     = '0;
               state_in   = wlcm_pkg::S_FRD;
            end else begin
               state_in = wlcm_pkg::S_FILL;
            end
         end
         wlcm_pkg::S_FRD: begin
            cmd.rd_slot = cnt_ff[SB-1:0];
            state_in    = wlcm_pkg::S_FWR;
         end
         wlcm_pkg::S_FWR: begin
            main_we    = crsp.dirty;
            main_waddr = crsp.tag;
            main_wdata = crsp.data;
            cnt_in     = cnt_ff + 1'b1;
            if ({1'b0, cnt_ff[SB-1:0]} == fill_ff - 1'b1) begin
               fill_in  = '0;
               state_in = is_rw ? wlcm_pkg::S_FILL : wlcm_pkg::S_DONE;
            end else begin
               state_in = wlcm_pkg::S_FRD;
            end
         end
         wlcm_pkg::S_FILL: begin
            cmd.map_we  = 1'b1;
            cmd.line_we = 1'b1;
            cmd.slot    = fill_ff[SB-1:0];
            cmd.dirty   = is_write;
            cmd.data    = is_write ? data_ff : mainq_ff;
            rd_in       = is_write ? data_ff : mainq_ff;
            fill_in     = fill_ff + 1'b1;
            state_in    = wlcm_pkg::S_DONE;
         end
         wlcm_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = {flushed_ff, hit_ff, rd_ff};
               clr_rsp_in   = 1'b0;
               state_in     = wlcm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = wlcm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wlcm_pkg::S_CLEAR;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      addr_ff    <= addr_in;
      data_ff    <= data_in;
      slot_ff    <= slot_in;
      mainq_ff   <= mainq_in;
      rd_ff      <= rd_in;
      hit_ff     <= hit_in;
      flushed_ff <= flushed_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ff};

endmodule

// File: design/wlcm_checker.sv
// Port-level checker for the wear-leveling cached memory, with its bind.
module wlcm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [39:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_hit_no_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[16] && rsp_tdata[17]))
      else $error("hit and flush flagged together");

   a_flush_no_data: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
      (req_tdata[2:0] == wlcm_pkg::OP_FLUSH || req_tdata[2:0] == wlcm_pkg::OP_REMAP)
      |=> !req_tready)
      else $error("flush request not sequenced");

endmodule

bind wear_leveling_cached_memory wlcm_checker u_wlcm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: verif/tb_top.sv
// Testbench for the wear-leveling cached memory: queued driver, predictor and response check.
`timescale 1ns / 1ps

module tb_top;

   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [9:0]  shift;
      logic [15:0] wdata;
      logic [9:0]  addr;
      logic [2:0]  op;
   } req_item_type;

   typedef struct {
      logic [15:0] rdata;
      logic        hit;
      logic        flushed;
   } rsp_item_type;

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid, rsp_tready;
   logic [23:0] rsp_tdata;

   wear_leveling_cached_memory u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // predictor state
   logic [15:0] mem_word [wlcm_pkg::MAIN_WORDS];
   logic [15:0] line_word [wlcm_pkg::CACHE_WORDS];
   logic [1:0]  line_state [wlcm_pkg::MAIN_WORDS];
   logic [5:0]  line_of [wlcm_pkg::MAIN_WORDS];
   int unsigned lines_used;
   int unsigned rot;

   req_item_type pending_reqs [$];
   rsp_item_type expected_rsps [$];
   int  errors = 0;
   int  req_count = 0, rsp_count = 0, flush_count = 0, hit_count = 0;
   int  idle_cycles = 0;
   bit  hold_off = 0;
   int  hold_left = 0;
   logic req_tready_seen;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   function automatic void spill_lines();
      for (int p = 0; p < wlcm_pkg::MAIN_WORDS; p++) begin
         if (line_state[p] == 2) mem_word[p] = line_word[line_of[p]];
         line_state[p] = 0;
         line_of[p] = 0;
      end
      lines_used = 0;
   endfunction

   function automatic rsp_item_type predict_access(req_item_type r);
      rsp_item_type o;
      int unsigned phys, s;
      logic [15:0] tmp [wlcm_pkg::MAIN_WORDS];
      o.rdata = 0; o.hit = 0; o.flushed = 0;
      phys = (r.addr + wlcm_pkg::MAIN_WORDS - rot) % wlcm_pkg::MAIN_WORDS;
      case (r.op)
         wlcm_pkg::OP_READ, wlcm_pkg::OP_WRITE: begin
            if (line_state[phys] != 0) begin
               o.hit = 1;
               if (r.op == wlcm_pkg::OP_READ) o.rdata = line_word[line_of[phys]];
               else line_word[line_of[phys]] = r.wdata;
            end else begin
               if (lines_used >= wlcm_pkg::CACHE_WORDS) begin
                  spill_lines();
                  o.flushed = 1;
               end
               line_of[phys] = 6'(lines_used);
               line_word[lines_used] = (r.op == wlcm_pkg::OP_READ) ? mem_word[phys] : r.wdata;
               if (r.op == wlcm_pkg::OP_READ) begin
                  o.rdata = mem_word[phys];
                  line_state[phys] = 1;
               end
               lines_used++;
            end
            if (r.op == wlcm_pkg::OP_WRITE) begin
               line_state[phys] = 2;
               o.rdata = r.wdata;
            end
         end
         wlcm_pkg::OP_FLUSH: begin
            spill_lines();
            o.flushed = 1;
         end
         wlcm_pkg::OP_REMAP: begin
            s = r.shift % (wlcm_pkg::MAIN_WORDS - 1);
            spill_lines();
            o.flushed = 1;
            if (s != 0) begin
               for (int p = 0; p < wlcm_pkg::MAIN_WORDS; p++)
                  tmp[p] = mem_word[(p + s) % wlcm_pkg::MAIN_WORDS];
               mem_word = tmp;
               rot = (rot + s) % wlcm_pkg::MAIN_WORDS;
            end
         end
         wlcm_pkg::OP_CLEAR: begin
            for (int p = 0; p < wlcm_pkg::MAIN_WORDS; p++) begin
               mem_word[p] = 0; line_state[p] = 0; line_of[p] = 0;
            end
            for (int i = 0; i < wlcm_pkg::CACHE_WORDS; i++) line_word[i] = 0;
            lines_used = 0;
         end
         default: ;
      endcase
      return o;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_tready_seen) begin
         if (pending_reqs.size() > 0 && $urandom_range(0, 3) != 0) begin
            req_tvalid <= 1;
            req_tdata  <= {1'b0, pending_reqs.pop_front()};
         end else if (pending_reqs.size() > 0 && $urandom_range(0, 40) == 0) begin
            req_tvalid <= 0;
            repeat ($urandom_range(5, 60)) @(negedge clock);
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   always @(posedge clock) req_tready_seen <= req_tvalid && req_tready;

   // receiver back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 0;
      end else if (hold_off) begin
         hold_left <= 3000;
         rsp_tready <= 0;
      end else begin
         case ($urandom_range(0, 19))
            0: begin
               hold_left <= $urandom_range(10, 80);
               rsp_tready <= 0;
            end
            1, 2, 3: rsp_tready <= 0;
            default: rsp_tready <= 1;
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type act, exp_rsp;
      req_item_type r;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            r = req_item_type'(req_tdata[38:0]);
            expected_rsps.push_back(predict_access(r));
            req_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            act.rdata = rsp_tdata[15:0];
            act.hit = rsp_tdata[16];
            act.flushed = rsp_tdata[17];
            rsp_count++;
            if (act.flushed) flush_count++;
            if (act.hit) hit_count++;
            if (expected_rsps.size() == 0) begin
               $error("response with none expected: %h", rsp_tdata);
               errors++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (act.rdata !== exp_rsp.rdata) begin
                  $error("read_data expected %h actual %h", exp_rsp.rdata, act.rdata);
                  errors++;
               end
               if (act.hit !== exp_rsp.hit) begin
                  $error("cache_hit expected %0d actual %0d", exp_rsp.hit, act.hit);
                  errors++;
               end
               if (act.flushed !== exp_rsp.flushed) begin
                  $error("flushed expected %0d actual %0d", exp_rsp.flushed, act.flushed);
                  errors++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic req_item_type mk(logic [2:0] op, int a, int d, int s);
      req_item_type r;
      r.op = op; r.addr = 10'(a); r.wdata = 16'(d); r.shift = 10'(s);
      return r;
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int base, n;
      req_item_type r;
      reset = 1;
      for (int p = 0; p < wlcm_pkg::MAIN_WORDS; p++) begin
         mem_word[p] = 0; line_state[p] = 0; line_of[p] = 0;
      end
      for (int i = 0; i < wlcm_pkg::CACHE_WORDS; i++) line_word[i] = 0;
      lines_used = 0;
      rot = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed
      pending_reqs.push_back(mk(wlcm_pkg::OP_READ, 0, 0, 0));
      pending_reqs.push_back(mk(wlcm_pkg::OP_WRITE, 1023, 16'hFFFF, 0));
      pending_reqs.push_back(mk(wlcm_pkg::OP_WRITE, 0, 16'h0000, 0));
      pending_reqs.push_back(mk(wlcm_pkg::OP_READ, 1023, 0, 0));
      pending_reqs.push_back(mk(wlcm_pkg::OP_WRITE, 1023, 16'hA5A5, 0));
      pending_reqs.push_back(mk(wlcm_pkg::OP_FLUSH, 0, 0, 0));
      pending_reqs.push_back(mk(wlcm_pkg::OP_READ, 1023, 0, 0));
      pending_reqs.push_back(mk(wlcm_pkg::OP_REMAP, 0, 0, 0));
      pending_reqs.push_back(mk(wlcm_pkg::OP_REMAP, 0, 0, 1022));
      pending_reqs.push_back(mk(wlcm_pkg::OP_REMAP, 0, 0, 1));
      pending_reqs.push_back(mk(wlcm_pkg::OP_READ, 0, 0, 0));
      pending_reqs.push_back(mk(wlcm_pkg::OP_READ, 1023, 0, 0));
      pending_reqs.push_back(mk(wlcm_pkg::OP_REMAP, 0, 0, 1023));
      pending_reqs.push_back(mk(3'd5, 10'h3FF, 16'hFFFF, 10'h3FF));
      pending_reqs.push_back(mk(3'd7, 0, 0, 0));
      for (int i = 0; i < 66; i++)
         pending_reqs.push_back(mk(wlcm_pkg::OP_WRITE, i, i * 977, 0));
      pending_reqs.push_back(mk(wlcm_pkg::OP_READ, 1023, 0, 0));
      pending_reqs.push_back(mk(wlcm_pkg::OP_CLEAR, 0, 0, 0));
      pending_reqs.push_back(mk(wlcm_pkg::OP_READ, 1023, 0, 0));
      wait_drained();

      // long receiver hold while requests keep coming
      hold_off = 1;
      for (int i = 0; i < 20; i++)
         pending_reqs.push_back(mk(wlcm_pkg::OP_WRITE, $urandom_range(0, 1023), $urandom, 0));
      repeat (20) @(posedge clock);
      hold_off = 0;
      wait_drained();

      // random: mostly accesses in a small window so hits and fills occur
      for (int blk = 0; blk < 40; blk++) begin
         base = $urandom_range(0, 1023);
         n = (blk % 8 == 7) ? 80 : $urandom_range(10, 30);
         for (int i = 0; i < n; i++) begin
            r.addr = (blk % 5 == 4) ? 10'($urandom_range(0, 1023))
                                    : 10'((base + $urandom_range(0, 40)) % 1024);
            r.wdata = 16'($urandom);
            r.shift = 10'($urandom_range(0, 1023));
            case ($urandom_range(0, 99))
               0, 1: r.op = wlcm_pkg::OP_FLUSH;
               2, 3: r.op = wlcm_pkg::OP_REMAP;
               4: r.op = (blk % 4 == 0) ? wlcm_pkg::OP_CLEAR : wlcm_pkg::OP_READ;
               5: r.op = 3'($urandom_range(5, 7));
               default: r.op = $urandom_range(0, 1) ? wlcm_pkg::OP_WRITE : wlcm_pkg::OP_READ;
            endcase
            pending_reqs.push_back(r);
         end
         if (blk % 10 == 9) wait_drained();
      end
      wait_drained();
      repeat (2000) @(posedge clock);

      $display("Covered %0d requests, %0d responses, %0d flushing, %0d hits.",
               req_count, rsp_count, flush_count, hit_count);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
